/* rtl/core/arpc_pkg.sv */
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants of the ARP cache resolver
// Field widths, function and status codes, and the structs that travel
// along the cell chain.
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int IP_W              = 32;
	localparam int MAC_W             = 48;
	localparam int RX_OP_W           = 16;
	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int CFG_IDX_W         = 1;

	localparam logic [MAC_W-1:0] BCAST_MAC = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MY_IP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MY_MAC = 1'd1;

	// item functions
	typedef enum logic [2:0] {
		FN_RESOLVE = 3'd0,
		FN_RX      = 3'd1,
		FN_ADD     = 3'd2,
		FN_DELETE  = 3'd3,
		FN_CLEAR   = 3'd4
	} func_t;

	// result status codes
	localparam logic [2:0] STAT_DONE     = 3'd0;
	localparam logic [2:0] STAT_REQ      = 3'd1;
	localparam logic [2:0] STAT_PEND     = 3'd2;
	localparam logic [2:0] STAT_RESOLVED = 3'd3;
	localparam logic [2:0] STAT_REPLY    = 3'd4;
	localparam logic [2:0] STAT_FULL     = 3'd5;
	localparam logic [2:0] STAT_IGNORED  = 3'd6;

	// received and emitted ARP operations
	localparam logic [RX_OP_W-1:0] RX_OP_REQ = 16'd1;
	localparam logic [RX_OP_W-1:0] RX_OP_REP = 16'd2;
	localparam logic [1:0]         TX_OP_REQ = 2'd1;
	localparam logic [1:0]         TX_OP_REP = 2'd2;

	// search probe walking the chain; slot indexes travel beside it
	typedef struct packed {
		logic             vld;
		logic             hit;
		logic             hit_res;
		logic [MAC_W-1:0] hit_mac;
		logic             free;
	} probe_t;

	// entry write data
	typedef struct packed {
		logic             vld;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
		logic             res;
	} entry_t;

endpackage

/* rtl/core/arpc_cell.sv */
// ----------------------------------------------------------------------------
// arpc_cell: one table slot of the ARP cache
// Holds one entry and one stage of the search probe. The probe picks up the
// first matching slot and the first free slot as it passes.
// ----------------------------------------------------------------------------
module arpc_cell #(
	parameter int IDX = 0,
	parameter int IW  = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [arpc_pkg::IP_W-1:0] key,
	input  arpc_pkg::probe_t        probe_i,
	input  logic [IW-1:0]           hit_idx_i,
	input  logic [IW-1:0]           free_idx_i,
	output arpc_pkg::probe_t        probe_o,
	output logic [IW-1:0]           hit_idx_o,
	output logic [IW-1:0]           free_idx_o,
	input  logic                    wr_en,
	input  logic [IW-1:0]           wr_idx,
	input  arpc_pkg::entry_t        wr_data,
	input  logic                    clr_all
);
	import arpc_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic             vld_q;
	logic [IP_W-1:0]  ip_q;
	logic [MAC_W-1:0] mac_q;
	logic             res_q;

	probe_t          probe_n, probe_q;
	logic [IW-1:0]   hit_idx_n, hit_idx_q;
	logic [IW-1:0]   free_idx_n, free_idx_q;

	// entry valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (clr_all) begin
			vld_q <= 1'b0;
		end else if (wr_en && wr_idx == MY_IDX) begin
			vld_q <= wr_data.vld;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == MY_IDX) begin
			ip_q  <= wr_data.ip;
			mac_q <= wr_data.mac;
			res_q <= wr_data.res;
		end
	end

	// probe update: first match and first free slot win
	always_comb begin
		probe_n    = probe_i;
		hit_idx_n  = hit_idx_i;
		free_idx_n = free_idx_i;
		if (probe_i.vld) begin
			if (!probe_i.hit && vld_q && ip_q == key) begin
				probe_n.hit     = 1'b1;
				probe_n.hit_res = res_q;
				probe_n.hit_mac = mac_q;
				hit_idx_n       = MY_IDX;
			end
			if (!probe_i.free && !vld_q) begin
				probe_n.free = 1'b1;
				free_idx_n   = MY_IDX;
			end
		end
	end

	// probe stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_n;
		end
	end

	always_ff @(posedge clk) begin
		hit_idx_q  <= hit_idx_n;
		free_idx_q <= free_idx_n;
	end

	assign probe_o    = probe_q;
	assign hit_idx_o  = hit_idx_q;
	assign free_idx_o = free_idx_q;

endmodule

/* rtl/core/arp_cache_resolver.sv */
// ----------------------------------------------------------------------------
// arp_cache_resolver: ARP address resolution cache
// IPv4-to-MAC table in a chain of slot cells, with resolve, received frame,
// add, delete and clear operations.
// ----------------------------------------------------------------------------
// One item is in work at a time. The accepted input beat starts the search
// probe through the start register; the probe then walks the slot chain one
// cell per cycle, registered in each cell. The tail outcome is then latched
// in its own register. The decision, together with the write of the chosen
// slot, loads the output register, which presents the result beat. The next
// input beat can be taken in the cycle after the decision. The result sits
// in an output register, so the next item is taken
// while it waits. A decision that finds the previous result still waiting
// stalls until that beat is taken. Configuration writes are taken in any
// cycle (cfg_ready is always high); index 0 is my_ip (cfg_data[31:0]),
// index 1 is my_mac.
module arp_cache_resolver #(
	parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [arpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [arpc_pkg::MAC_W-1:0]    cfg_data,
	// items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    func,
	input  logic [arpc_pkg::RX_OP_W-1:0]  opcode,
	input  logic [arpc_pkg::IP_W-1:0]     sender_ip,
	input  logic [arpc_pkg::MAC_W-1:0]    sender_mac,
	input  logic [arpc_pkg::IP_W-1:0]     target_ip,
	input  logic                          entry_complete,
	// results
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic                          frame_valid,
	output logic [1:0]                    frame_opcode,
	output logic [arpc_pkg::MAC_W-1:0]    frame_sender_mac,
	output logic [arpc_pkg::IP_W-1:0]     frame_sender_ip,
	output logic [arpc_pkg::MAC_W-1:0]    frame_target_mac,
	output logic [arpc_pkg::IP_W-1:0]     frame_target_ip,
	output logic [arpc_pkg::MAC_W-1:0]    resolved_mac
);
	import arpc_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SEARCH = 3'b010,
		S_DECIDE = 3'b100
	} state_t;

	state_t state_q;

	logic [IP_W-1:0]    my_ip_q;
	logic [MAC_W-1:0]   my_mac_q;

	logic [2:0]         func_q;
	logic [RX_OP_W-1:0] opcode_q;
	logic [IP_W-1:0]    s_ip_q;
	logic [MAC_W-1:0]   s_mac_q;
	logic [IP_W-1:0]    t_ip_q;
	logic               comp_q;
	logic [IP_W-1:0]    key_q;
	logic               start_q;

	probe_t             fin_q;
	logic [IW-1:0]      fin_hit_idx_q, fin_free_idx_q;

	probe_t             probe   [TABLE_ENTRIES+1];
	logic [IW-1:0]      hit_idx [TABLE_ENTRIES+1];
	logic [IW-1:0]      free_idx[TABLE_ENTRIES+1];

	logic               wr_en;
	logic [IW-1:0]      wr_idx;
	entry_t             wr_data;
	logic               clr_all;

	logic               in_acc;
	logic               commit;

	logic               out_valid_q;
	logic [2:0]         status_n, status_q;
	logic               fv_n, fv_q;
	logic [1:0]         fop_n, fop_q;
	logic [MAC_W-1:0]   fsmac_n, fsmac_q;
	logic [IP_W-1:0]    fsip_n, fsip_q;
	logic [MAC_W-1:0]   ftmac_n, ftmac_q;
	logic [IP_W-1:0]    ftip_n, ftip_q;
	logic [MAC_W-1:0]   rmac_n, rmac_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_ip_q  <= '0;
			my_mac_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MY_IP:  my_ip_q  <= cfg_data[IP_W-1:0];
				CFG_MY_MAC: my_mac_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshakes
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign commit   = (state_q == S_DECIDE) && (!out_valid_q || out_ready);

	// item capture; a received reply is keyed by its sender IP
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q   <= func;
			opcode_q <= opcode;
			s_ip_q   <= sender_ip;
			s_mac_q  <= sender_mac;
			t_ip_q   <= target_ip;
			comp_q   <= entry_complete;
			key_q    <= (func_t'(func) == FN_RX) ? sender_ip : target_ip;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= in_acc;
			case (state_q)
				S_IDLE:   if (in_acc) state_q <= S_SEARCH;
				S_SEARCH: if (probe[TABLE_ENTRIES].vld) state_q <= S_DECIDE;
				S_DECIDE: if (commit) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// probe enters at the head of the chain
	assign probe[0]    = '{vld: start_q, hit: 1'b0, hit_res: 1'b0, hit_mac: '0, free: 1'b0};
	assign hit_idx[0]  = '0;
	assign free_idx[0] = '0;

	// slot chain
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		arpc_cell #(
			.IDX (i),
			.IW  (IW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.key        (key_q),
			.probe_i    (probe[i]),
			.hit_idx_i  (hit_idx[i]),
			.free_idx_i (free_idx[i]),
			.probe_o    (probe[i+1]),
			.hit_idx_o  (hit_idx[i+1]),
			.free_idx_o (free_idx[i+1]),
			.wr_en      (wr_en),
			.wr_idx     (wr_idx),
			.wr_data    (wr_data),
			.clr_all    (clr_all)
		);
	end

	// search outcome at the tail
	always_ff @(posedge clk) begin
		if (probe[TABLE_ENTRIES].vld) begin
			fin_q          <= probe[TABLE_ENTRIES];
			fin_hit_idx_q  <= hit_idx[TABLE_ENTRIES];
			fin_free_idx_q <= free_idx[TABLE_ENTRIES];
		end
	end

	// decision: table write and result
	always_comb begin
		wr_en    = 1'b0;
		wr_idx   = fin_hit_idx_q;
		wr_data  = '{vld: 1'b1, ip: key_q, mac: s_mac_q, res: 1'b1};
		clr_all  = 1'b0;
		status_n = STAT_IGNORED;
		fv_n     = 1'b0;
		fop_n    = '0;
		fsmac_n  = '0;
		fsip_n   = '0;
		ftmac_n  = '0;
		ftip_n   = '0;
		rmac_n   = '0;
		case (func_t'(func_q))
			FN_RESOLVE: begin
				if (fin_q.hit) begin
					if (fin_q.hit_res) begin
						status_n = STAT_RESOLVED;
						rmac_n   = fin_q.hit_mac;
					end else begin
						status_n = STAT_PEND;
					end
				end else if (fin_q.free) begin
					wr_en    = 1'b1;
					wr_idx   = fin_free_idx_q;
					wr_data  = '{vld: 1'b1, ip: t_ip_q, mac: BCAST_MAC, res: 1'b0};
					status_n = STAT_REQ;
					fv_n     = 1'b1;
					fop_n    = TX_OP_REQ;
					fsmac_n  = my_mac_q;
					fsip_n   = s_ip_q;
					ftmac_n  = BCAST_MAC;
					ftip_n   = t_ip_q;
				end else begin
					status_n = STAT_FULL;
				end
			end
			FN_RX: begin
				if (opcode_q == RX_OP_REQ) begin
					if (t_ip_q == my_ip_q) begin
						status_n = STAT_REPLY;
						fv_n     = 1'b1;
						fop_n    = TX_OP_REP;
						fsmac_n  = my_mac_q;
						fsip_n   = my_ip_q;
						ftmac_n  = s_mac_q;
						ftip_n   = s_ip_q;
					end
				end else if (opcode_q == RX_OP_REP) begin
					if (fin_q.hit) begin
						wr_en    = 1'b1;
						status_n = STAT_DONE;
					end
				end
			end
			FN_ADD: begin
				wr_data = '{vld: 1'b1, ip: t_ip_q, mac: s_mac_q, res: comp_q};
				if (fin_q.hit) begin
					wr_en    = 1'b1;
					status_n = STAT_DONE;
				end else if (fin_q.free) begin
					wr_en    = 1'b1;
					wr_idx   = fin_free_idx_q;
					status_n = STAT_DONE;
				end else begin
					status_n = STAT_FULL;
				end
			end
			FN_DELETE: begin
				wr_en        = fin_q.hit;
				wr_data.vld  = 1'b0;
				status_n     = STAT_DONE;
			end
			FN_CLEAR: begin
				clr_all  = 1'b1;
				status_n = STAT_DONE;
			end
			default: ;
		endcase
		// table changes only in the commit cycle
		wr_en   = wr_en && commit;
		clr_all = clr_all && commit;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= status_n;
			fv_q     <= fv_n;
			fop_q    <= fop_n;
			fsmac_q  <= fsmac_n;
			fsip_q   <= fsip_n;
			ftmac_q  <= ftmac_n;
			ftip_q   <= ftip_n;
			rmac_q   <= rmac_n;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign frame_valid      = fv_q;
	assign frame_opcode     = fop_q;
	assign frame_sender_mac = fsmac_q;
	assign frame_sender_ip  = fsip_q;
	assign frame_target_mac = ftmac_q;
	assign frame_target_ip  = ftip_q;
	assign resolved_mac     = rmac_q;

endmodule

/* rtl/core/arpc_checker.sv */
// ----------------------------------------------------------------------------
// arpc_checker: port-level checks of the ARP cache resolver
// Watches the top level's ports and flags inconsistent result beats.
// ----------------------------------------------------------------------------
module arpc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [2:0]                    status,
	input  logic                          frame_valid,
	input  logic [1:0]                    frame_opcode,
	input  logic [arpc_pkg::MAC_W-1:0]    frame_sender_mac,
	input  logic [arpc_pkg::IP_W-1:0]     frame_sender_ip,
	input  logic [arpc_pkg::MAC_W-1:0]    frame_target_mac,
	input  logic [arpc_pkg::IP_W-1:0]     frame_target_ip,
	input  logic [arpc_pkg::MAC_W-1:0]    resolved_mac
);
	import arpc_pkg::*;

	// one item in work: no new beat right after an accepted one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(frame_valid) && $stable(resolved_mac))
		else $error("stalled result beat changed");

	// no frame means all frame fields zero
	a_no_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_valid |-> frame_opcode == '0 && frame_sender_mac == '0
			&& frame_sender_ip == '0 && frame_target_mac == '0 && frame_target_ip == '0)
		else $error("frame fields set without a frame");

	// resolved MAC only on a complete hit
	a_rmac_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_RESOLVED |-> resolved_mac == '0)
		else $error("resolved MAC outside a resolved status");

	// a frame is a broadcast request or a reply, matching the status
	a_frame_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_valid |->
			(status == STAT_REQ && frame_opcode == TX_OP_REQ && frame_target_mac == BCAST_MAC)
			|| (status == STAT_REPLY && frame_opcode == TX_OP_REP))
		else $error("emitted frame does not match status");

endmodule

bind arp_cache_resolver arpc_checker u_arpc_checker (.*);
